FILE: hdl/symmetric_heuristic_cache_defines.svh
// Assertion macros for the symmetric heuristic cache.
// Included by the top level; depends on nothing else.
`ifndef SYMMETRIC_HEURISTIC_CACHE_DEFINES_SVH
`define SYMMETRIC_HEURISTIC_CACHE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shc assertion failed");

// Next-cycle implication, checked outside reset.
`define SHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shc assertion failed");

`endif

FILE: hdl/shc_pkg.sv
// Shared types and constants for the symmetric heuristic cache.
// Used by every module of the block; depends on nothing.
package shc_pkg;

    localparam int KEY_W     = 64;
    localparam int COST_W    = 32;
    localparam int IDX8_W    = 8;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 8;
    localparam int OPND_W    = 10;   // signed dividend of the fold remainders
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W    = 1;
    localparam int QCNT_W    = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT_CNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_PARTS = 4'd1;

    localparam logic [IDX8_W-1:0] ORIENT_CNT_RST  = 8'd16;
    localparam logic [IDX8_W-1:0] STEER_PARTS_RST = 8'd1;

    localparam logic [1:0] FOLD_HALF    = 2'd0;
    localparam logic [1:0] FOLD_QUARTER = 2'd1;
    localparam logic [1:0] FOLD_EIGHTH  = 2'd2;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_FOLD,
        FR_MOD_START,
        FR_MOD_WAIT,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        TGT_GH,
        TGT_SS,
        TGT_GS
    } t_target;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DONE
    } t_back_state;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key;
        logic [COST_W-1:0] cost;
    } t_req;

    typedef struct packed {
        logic                     start;
        logic signed [OPND_W-1:0] dividend;
        logic [IDX8_W-1:0]        divisor;
    } t_rem_req;

    typedef struct packed {
        logic              done;
        logic [IDX8_W-1:0] result;
    } t_rem_rsp;

endpackage

FILE: hdl/shc_req_if.sv
// Request channel of the symmetric heuristic cache: valid, ready, pose pair.
// Depends on nothing.
interface shc_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [7:0]  start_heading;
    logic [7:0]  start_steer;
    logic [15:0] goal_x;
    logic [15:0] goal_y;
    logic [7:0]  goal_heading;
    logic [7:0]  goal_steer;
    logic [31:0] cost_in;

    modport source (
        output valid, func, start_x, start_y, start_heading, start_steer,
               goal_x, goal_y, goal_heading, goal_steer, cost_in,
        input  ready
    );
    modport sink (
        input  valid, func, start_x, start_y, start_heading, start_steer,
               goal_x, goal_y, goal_heading, goal_steer, cost_in,
        output ready
    );
endinterface

FILE: hdl/shc_rsp_if.sv
// Response channel of the symmetric heuristic cache: valid, ready, result.
// Depends on nothing.
interface shc_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] cost_out;
    logic [63:0] canon_key;

    modport source (
        output valid, status, cost_out, canon_key,
        input  ready
    );
    modport sink (
        input  valid, status, cost_out, canon_key,
        output ready
    );
endinterface

FILE: hdl/shc_rem.sv
// Bit-serial truncating remainder of a small signed value by an 8-bit count.
// Depends on shc_pkg.
module shc_rem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  shc_pkg::t_rem_req  i_req,
    output shc_pkg::t_rem_rsp  o_rsp
);
    localparam int MAG_W = shc_pkg::OPND_W - 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [MAG_W-1:0]              r_mag;
    logic [shc_pkg::IDX8_W-1:0]    r_rem;
    logic [shc_pkg::IDX8_W-1:0]    r_div;
    logic [shc_pkg::IDX8_W-1:0]    r_low;
    logic [shc_pkg::IDX8_W-1:0]    r_result;
    logic                          r_neg;
    logic [shc_pkg::IDX8_W:0]      shifted;
    logic [shc_pkg::IDX8_W-1:0]    rem_step;
    logic [shc_pkg::OPND_W-1:0]    neg_dividend;

    always_comb begin
        shifted      = {r_rem, r_mag[MAG_W-1]};
        rem_step     = (shifted >= {1'b0, r_div}) ?
                       shifted[shc_pkg::IDX8_W-1:0] - r_div : shifted[shc_pkg::IDX8_W-1:0];
        neg_dividend = shc_pkg::OPND_W'(0) - i_req.dividend;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift one dividend bit in per cycle
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg <= i_req.dividend[shc_pkg::OPND_W-1];
            r_mag <= i_req.dividend[shc_pkg::OPND_W-1] ? neg_dividend[MAG_W-1:0]
                                                       : i_req.dividend[MAG_W-1:0];
            r_rem <= '0;
            r_div <= i_req.divisor;
            r_low <= i_req.dividend[shc_pkg::IDX8_W-1:0];
        end else if (r_busy) begin
            r_rem <= rem_step;
            r_mag <= {r_mag[MAG_W-2:0], 1'b0};
            if (r_cnt == CNT_W'(1)) begin
                if (r_div == '0) begin
                    r_result <= r_low;
                end else if (r_neg) begin
                    r_result <= shc_pkg::IDX8_W'(0) - rem_step;
                end else begin
                    r_result <= rem_step;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule

FILE: hdl/shc_front.sv
// Front end: accepts a pose pair, folds it into the first octant, queues the key.
// Depends on shc_pkg, shc_req_if and shc_rem.
module shc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [shc_pkg::IDX8_W-1:0] i_orient_cnt,
    input  logic [shc_pkg::IDX8_W-1:0] i_steer_parts,
    shc_req_if.sink                    i_req,
    output logic                       o_q_valid,
    input  logic                       i_q_ready,
    output shc_pkg::t_req              o_q_data
);
    localparam int W8 = shc_pkg::IDX8_W;

    shc_pkg::t_front_state r_state, n_state;
    shc_pkg::t_target      r_tgt, n_tgt;
    logic [1:0]            r_fold, n_fold;
    logic [15:0]           r_dx, n_dx, r_dy, n_dy;
    logic [W8-1:0]         r_sh, n_sh, r_gh, n_gh, r_ss, n_ss, r_gs, n_gs;
    logic                  r_func, n_func;
    logic [shc_pkg::COST_W-1:0] r_cost, n_cost;

    logic [W8-1:0]         half_o, quarter_o, eighth_o, bound;
    logic                  fold_take;
    shc_pkg::t_rem_req     rem_req;
    shc_pkg::t_rem_rsp     rem_rsp;

    shc_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rem_req),
        .o_rsp   (rem_rsp)
    );

    always_comb begin
        half_o    = i_orient_cnt >> 1;
        quarter_o = i_orient_cnt >> 2;
        eighth_o  = i_orient_cnt >> 3;
        case (r_fold)
            shc_pkg::FOLD_HALF:    bound = half_o;
            shc_pkg::FOLD_QUARTER: bound = quarter_o;
            default:               bound = eighth_o;
        endcase
        fold_take = r_sh > bound;
    end

    // divider operand: heading folds about the axis, steering reflects about zero
    always_comb begin
        rem_req.start = (r_state == shc_pkg::FR_MOD_START);
        case (r_tgt)
            shc_pkg::TGT_GH: begin
                rem_req.dividend = {2'b00, i_orient_cnt}
                    + ((r_fold == shc_pkg::FOLD_QUARTER) ? {2'b00, half_o} : {2'b00, quarter_o})
                    - {2'b00, r_gh};
                rem_req.divisor  = i_orient_cnt;
            end
            shc_pkg::TGT_SS: begin
                rem_req.dividend = {2'b00, i_steer_parts} - {2'b00, r_ss};
                rem_req.divisor  = i_steer_parts;
            end
            default: begin
                rem_req.dividend = {2'b00, i_steer_parts} - {2'b00, r_gs};
                rem_req.divisor  = i_steer_parts;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            shc_pkg::FR_IDLE: begin
                if (i_req.valid) n_state = shc_pkg::FR_FOLD;
            end
            shc_pkg::FR_FOLD: begin
                if (fold_take) begin
                    n_state = shc_pkg::FR_MOD_START;
                end else if (r_fold == shc_pkg::FOLD_EIGHTH) begin
                    n_state = shc_pkg::FR_PUSH;
                end
            end
            shc_pkg::FR_MOD_START: n_state = shc_pkg::FR_MOD_WAIT;
            shc_pkg::FR_MOD_WAIT: begin
                if (rem_rsp.done) begin
                    if (r_tgt != shc_pkg::TGT_GS) begin
                        n_state = shc_pkg::FR_MOD_START;
                    end else if (r_fold == shc_pkg::FOLD_EIGHTH) begin
                        n_state = shc_pkg::FR_PUSH;
                    end else begin
                        n_state = shc_pkg::FR_FOLD;
                    end
                end
            end
            shc_pkg::FR_PUSH: begin
                if (i_q_ready) n_state = shc_pkg::FR_IDLE;
            end
            default: n_state = shc_pkg::FR_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_req.ready   = (r_state == shc_pkg::FR_IDLE);
        o_q_valid     = (r_state == shc_pkg::FR_PUSH);
    end

    // datapath next values
    always_comb begin
        n_tgt  = r_tgt;
        n_fold = r_fold;
        n_dx   = r_dx;
        n_dy   = r_dy;
        n_sh   = r_sh;
        n_gh   = r_gh;
        n_ss   = r_ss;
        n_gs   = r_gs;
        n_func = r_func;
        n_cost = r_cost;
        case (r_state)
            shc_pkg::FR_IDLE: begin
                n_fold = shc_pkg::FOLD_HALF;
                n_tgt  = shc_pkg::TGT_GH;
                n_dx   = i_req.goal_x - i_req.start_x;
                n_dy   = i_req.goal_y - i_req.start_y;
                n_sh   = i_req.start_heading;
                n_gh   = i_req.goal_heading;
                n_ss   = i_req.start_steer;
                n_gs   = i_req.goal_steer;
                n_func = i_req.func;
                n_cost = i_req.cost_in;
            end
            shc_pkg::FR_FOLD: begin
                if (fold_take) begin
                    case (r_fold)
                        shc_pkg::FOLD_HALF: begin
                            n_dy  = 16'd0 - r_dy;
                            n_sh  = i_orient_cnt - r_sh;
                            n_gh  = (r_gh == '0) ? '0 : i_orient_cnt - r_gh;
                            n_tgt = shc_pkg::TGT_SS;
                        end
                        shc_pkg::FOLD_QUARTER: begin
                            n_dx  = 16'd0 - r_dx;
                            n_sh  = half_o - r_sh;
                            n_tgt = shc_pkg::TGT_GH;
                        end
                        default: begin
                            n_dx  = r_dy;
                            n_dy  = r_dx;
                            n_sh  = quarter_o - r_sh;
                            n_tgt = shc_pkg::TGT_GH;
                        end
                    endcase
                end else if (r_fold != shc_pkg::FOLD_EIGHTH) begin
                    n_fold = r_fold + 2'd1;
                end
            end
            shc_pkg::FR_MOD_WAIT: begin
                if (rem_rsp.done) begin
                    case (r_tgt)
                        shc_pkg::TGT_GH: begin
                            n_gh  = rem_rsp.result;
                            n_tgt = shc_pkg::TGT_SS;
                        end
                        shc_pkg::TGT_SS: begin
                            n_ss  = rem_rsp.result;
                            n_tgt = shc_pkg::TGT_GS;
                        end
                        default: begin
                            n_gs  = rem_rsp.result;
                            n_tgt = shc_pkg::TGT_GH;
                            if (r_fold != shc_pkg::FOLD_EIGHTH) n_fold = r_fold + 2'd1;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shc_pkg::FR_IDLE;
            r_tgt   <= shc_pkg::TGT_GH;
            r_fold  <= shc_pkg::FOLD_HALF;
        end else begin
            r_state <= n_state;
            r_tgt   <= n_tgt;
            r_fold  <= n_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_sh   <= n_sh;
        r_gh   <= n_gh;
        r_ss   <= n_ss;
        r_gs   <= n_gs;
        r_func <= n_func;
        r_cost <= n_cost;
    end

    assign o_q_data.func = r_func;
    assign o_q_data.key  = {r_dx, r_dy, r_sh, r_gh, r_ss, r_gs};
    assign o_q_data.cost = r_cost;

endmodule

FILE: hdl/shc_fifo.sv
// Short request queue between the front end and the table scanner.
// Depends on shc_pkg.
module shc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  shc_pkg::t_req i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output shc_pkg::t_req o_data
);
    shc_pkg::t_req              r_mem [shc_pkg::QUEUE_DEPTH];
    logic [shc_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [shc_pkg::QCNT_W-1:0] r_count;
    logic                       push, pop;

    assign o_ready = (r_count != shc_pkg::QCNT_W'(shc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == shc_pkg::QPTR_W'(shc_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == shc_pkg::QPTR_W'(shc_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

FILE: hdl/shc_back.sv
// Back end: scans the key table one entry per cycle, then answers or inserts.
// Depends on shc_pkg and shc_rsp_if.
module shc_back #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  shc_pkg::t_req i_q_data,
    shc_rsp_if.source     o_rsp
);
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [shc_pkg::KEY_W-1:0]  mem_key  [TABLE_ENTRIES];
    logic [shc_pkg::COST_W-1:0] mem_cost [TABLE_ENTRIES];

    shc_pkg::t_back_state       r_state, n_state;
    shc_pkg::t_req              r_req;
    logic [FILL_W-1:0]          r_addr, r_fill;
    logic                       r_pend;
    logic                       r_found;
    logic [shc_pkg::COST_W-1:0] r_hit_cost;
    logic [shc_pkg::KEY_W-1:0]  r_key_q;
    logic [shc_pkg::COST_W-1:0] r_cost_q;
    logic                       r_out_valid;
    shc_pkg::t_status           r_out_status, n_out_status;
    logic [shc_pkg::COST_W-1:0] r_out_cost;
    logic [shc_pkg::KEY_W-1:0]  r_out_key;

    logic match, scan_end, rd_en, wr_en, out_free, load_out, table_full;

    always_comb begin
        match      = r_pend && (r_key_q == r_req.key);
        scan_end   = match || (r_addr >= r_fill);
        out_free   = !r_out_valid || o_rsp.ready;
        table_full = (r_fill == FILL_W'(TABLE_ENTRIES));
        if (!r_req.func) begin
            n_out_status = r_found ? shc_pkg::ST_HIT : shc_pkg::ST_MISS;
        end else if (r_found) begin
            n_out_status = shc_pkg::ST_PRESENT;
        end else if (table_full) begin
            n_out_status = shc_pkg::ST_FULL;
        end else begin
            n_out_status = shc_pkg::ST_INSERTED;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            shc_pkg::BK_IDLE: if (i_q_valid) n_state = shc_pkg::BK_SCAN;
            shc_pkg::BK_SCAN: if (scan_end) n_state = shc_pkg::BK_DONE;
            shc_pkg::BK_DONE: if (out_free) n_state = shc_pkg::BK_IDLE;
            default:          n_state = shc_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_ready = (r_state == shc_pkg::BK_IDLE);
        rd_en     = (r_state == shc_pkg::BK_SCAN) && !scan_end;
        load_out  = (r_state == shc_pkg::BK_DONE) && out_free;
        wr_en     = load_out && (n_out_status == shc_pkg::ST_INSERTED);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shc_pkg::BK_IDLE;
            r_pend      <= 1'b0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_en;
            if (wr_en) r_fill <= r_fill + 1'b1;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_ready && i_q_valid) begin
            r_req  <= i_q_data;
            r_addr <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + 1'b1;
        end
        if ((r_state == shc_pkg::BK_SCAN) && scan_end) begin
            r_found    <= match;
            r_hit_cost <= r_cost_q;
        end
        if (load_out) begin
            r_out_status <= n_out_status;
            r_out_cost   <= (n_out_status == shc_pkg::ST_HIT) ? r_hit_cost : '0;
            r_out_key    <= r_req.key;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_key[r_fill[IDX_W-1:0]]  <= r_req.key;
            mem_cost[r_fill[IDX_W-1:0]] <= r_req.cost;
        end
        if (rd_en) begin
            r_key_q  <= mem_key[r_addr[IDX_W-1:0]];
            r_cost_q <= mem_cost[r_addr[IDX_W-1:0]];
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.cost_out  = r_out_cost;
    assign o_rsp.canon_key = r_out_key;

endmodule

FILE: hdl/symmetric_heuristic_cache.sv
// Flow: the fold front end works on one request at a time (each taken fold runs two or three
// serial remainders), then the key passes through the queue and the table scan.
// The front end can fold the next request while the scan works on an earlier one; the scan
// reads one stored key per cycle, so the scan grows longer as the table fills.
// Reset: synchronous, active low; the table is empty at once (fill count cleared,
// no clearing pass), orientation_count returns to 16 and steer_partitions to 1.
`include "symmetric_heuristic_cache_defines.svh"

module symmetric_heuristic_cache #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [shc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [shc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    shc_req_if.sink                       i_req,
    shc_rsp_if.source                     o_rsp
);
    // configuration registers; the user must write them only while the block is idle (not enforced here)
    logic [shc_pkg::IDX8_W-1:0] r_orient_cnt;
    logic [shc_pkg::IDX8_W-1:0] r_steer_parts;

    // front end to queue, queue to scanner
    logic          fq_valid, fq_ready;
    shc_pkg::t_req fq_data;
    logic          qb_valid, qb_ready;
    shc_pkg::t_req qb_data;

    // handshake terms for the checks at the end
    logic          rsp_no_hit;
    logic          req_fire;

    // Hold the register values; drop writes to unknown indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient_cnt  <= shc_pkg::ORIENT_CNT_RST;
            r_steer_parts <= shc_pkg::STEER_PARTS_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                shc_pkg::CFG_ORIENT_CNT:  r_orient_cnt  <= i_cfg_data;
                shc_pkg::CFG_STEER_PARTS: r_steer_parts <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: take one request, form the deltas, fold the start heading into
    // the first octant step by step and push the packed key.
    shc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_orient_cnt  (r_orient_cnt),
        .i_steer_parts (r_steer_parts),
        .i_req         (i_req),
        .o_q_valid     (fq_valid),
        .i_q_ready     (fq_ready),
        .o_q_data      (fq_data)
    );

    // Decouple folding from scanning so the next request folds during a long scan.
    shc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_data  (fq_data),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_data  (qb_data)
    );

    // Back end: search filled slots in order, answer through an output register,
    // append new keys at the fill count.
    shc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (qb_valid),
        .o_q_ready (qb_ready),
        .i_q_data  (qb_data),
        .o_rsp     (o_rsp)
    );

    assign rsp_no_hit = o_rsp.valid && (o_rsp.status != shc_pkg::ST_HIT);
    assign req_fire   = i_req.valid && i_req.ready;

    // Only a hit carries a cost.
    `SHC_ASSERT_SAME(a_cost_only_on_hit, i_clk, i_rst_n, rsp_no_hit, o_rsp.cost_out == '0)
    // The front end works on one request at a time.
    `SHC_ASSERT_NEXT(a_front_one_at_a_time, i_clk, i_rst_n, req_fire, !i_req.ready)

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the symmetric heuristic cache: directed table, then random requests.
// Depends on shc_pkg, shc_req_if, shc_rsp_if and the symmetric_heuristic_cache top level.

module tb_top;

    localparam int TABLE_ENTRIES  = 256;
    localparam int RANDOM_PHASES  = 7;
    localparam int PHASE_REQUESTS = 250;
    localparam int POOL_LIMIT     = 48;
    localparam int LONG_HOLD      = 500;     // receiver hold-off, in cycles
    localparam int HOLD_AFTER     = 100;     // answers seen before the hold-off starts
    localparam int DRAIN_CYCLES   = 400;     // front end plus a full scan, with margin
    localparam int CFG_FIRST_UNUSED = int'(shc_pkg::CFG_STEER_PARTS) + 1;
    localparam int CFG_LAST_INDEX   = (1 << shc_pkg::CFG_IDX_W) - 1;

    localparam logic FN_LOOKUP = 1'b0;
    localparam logic FN_INSERT = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [7:0]  start_heading;
        logic [7:0]  start_steer;
        logic [15:0] goal_x;
        logic [15:0] goal_y;
        logic [7:0]  goal_heading;
        logic [7:0]  goal_steer;
        logic [31:0] cost_in;
    } t_pose_req;

    typedef struct packed {
        shc_pkg::t_status           status;
        logic [shc_pkg::COST_W-1:0] cost;
        logic [shc_pkg::KEY_W-1:0]  key;
    } t_answer;

    // One row of the directed table: register setting, request, optional literal answer.
    typedef struct {
        logic [7:0] orient;
        logic [7:0] steer;
        t_pose_req  req;
        bit         typed;
        t_answer    answer;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                          i_cfg_wr_en;
    logic [shc_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [shc_pkg::CFG_DAT_W-1:0] i_cfg_data;

    shc_req_if req_ch ();
    shc_rsp_if rsp_ch ();

    symmetric_heuristic_cache #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the block: registers and the cost table.
    logic [7:0]                 orient_cnt;
    logic [7:0]                 steer_parts;
    logic [shc_pkg::KEY_W-1:0]  known_keys  [TABLE_ENTRIES];
    logic [shc_pkg::COST_W-1:0] known_costs [TABLE_ENTRIES];
    int                         entries_used;

    t_answer pending_answers[$];
    int      answers_seen;
    int      fails;
    int      status_seen[5];
    int      req_idle_pct;
    int      rsp_idle_pct;

    // Truncating remainder; a zero modulus passes the dividend through. Keep 8 bits.
    function automatic int rem_low8(input int a, input int m);
        int r;
        r = (m == 0) ? a : a % m;
        return r & 255;
    endfunction

    // Fold the pose pair into the first octant and pack the canonical key.
    function automatic logic [shc_pkg::KEY_W-1:0] fold_pose_key(input t_pose_req r);
        int o, p, sh, gh, ss, gs;
        logic [15:0] dx, dy, t;
        o  = int'(orient_cnt);
        p  = int'(steer_parts);
        dx = r.goal_x - r.start_x;
        dy = r.goal_y - r.start_y;
        sh = int'(r.start_heading);
        gh = int'(r.goal_heading);
        ss = int'(r.start_steer);
        gs = int'(r.goal_steer);
        if (sh > o / 2) begin
            dy = -dy;
            sh = (o - sh) & 255;
            gh = (gh == 0) ? 0 : ((o - gh) & 255);
            ss = rem_low8(p - ss, p);
            gs = rem_low8(p - gs, p);
        end
        if (sh > o / 4) begin
            dx = -dx;
            sh = (o / 2 - sh) & 255;
            gh = rem_low8(o + o / 2 - gh, o);
            ss = rem_low8(p - ss, p);
            gs = rem_low8(p - gs, p);
        end
        if (sh > o / 8) begin
            t  = dx;
            dx = dy;
            dy = t;
            sh = (o / 4 - sh) & 255;
            gh = rem_low8(o + o / 4 - gh, o);
            ss = rem_low8(p - ss, p);
            gs = rem_low8(p - gs, p);
        end
        return {dx, dy, sh[7:0], gh[7:0], ss[7:0], gs[7:0]};
    endfunction

    // Work out the answer to one accepted request and advance the shadow table.
    function automatic t_answer predict_answer(input t_pose_req r);
        t_answer a;
        int      hit_at;
        a.key    = fold_pose_key(r);
        a.cost   = '0;
        a.status = shc_pkg::ST_MISS;
        hit_at   = -1;
        for (int i = 0; i < entries_used; i++) begin
            if (hit_at < 0 && known_keys[i] == a.key) hit_at = i;
        end
        if (r.func == FN_LOOKUP) begin
            if (hit_at >= 0) begin
                a.status = shc_pkg::ST_HIT;
                a.cost   = known_costs[hit_at];
            end
        end else if (hit_at >= 0) begin
            a.status = shc_pkg::ST_PRESENT;
        end else if (entries_used >= TABLE_ENTRIES) begin
            a.status = shc_pkg::ST_FULL;
        end else begin
            known_keys[entries_used]  = a.key;
            known_costs[entries_used] = r.cost_in;
            entries_used++;
            a.status = shc_pkg::ST_INSERTED;
        end
        return a;
    endfunction

    function automatic t_dir_row stim_row(
        input logic [7:0] o, input logic [7:0] p, input logic fn,
        input logic [15:0] sx, input logic [15:0] sy, input logic [7:0] sh, input logic [7:0] ss,
        input logic [15:0] gx, input logic [15:0] gy, input logic [7:0] gh, input logic [7:0] gs,
        input logic [31:0] cost, input bit typed, input shc_pkg::t_status st,
        input logic [31:0] c_out, input logic [63:0] key);
        t_dir_row row;
        row.orient            = o;
        row.steer             = p;
        row.req.func          = fn;
        row.req.start_x       = sx;
        row.req.start_y       = sy;
        row.req.start_heading = sh;
        row.req.start_steer   = ss;
        row.req.goal_x        = gx;
        row.req.goal_y        = gy;
        row.req.goal_heading  = gh;
        row.req.goal_steer    = gs;
        row.req.cost_in       = cost;
        row.typed             = typed;
        row.answer.status     = st;
        row.answer.cost       = c_out;
        row.answer.key        = key;
        return row;
    endfunction

    // Draw a request that mostly respects the current heading and steering counts.
    function automatic t_pose_req random_pose();
        t_pose_req r;
        int o, p;
        o = int'(orient_cnt);
        p = int'(steer_parts);
        r.func    = 1'($urandom_range(1, 0));
        r.cost_in = 32'($urandom);
        r.start_x = 16'($urandom);
        r.start_y = 16'($urandom);
        // Short hops are the common case in a planner; long wraps are the noise.
        r.goal_x = ($urandom_range(1, 0) == 0) ? 16'($urandom)
                                                : r.start_x + 16'($urandom_range(31, 0)) - 16'd16;
        r.goal_y = ($urandom_range(1, 0) == 0) ? 16'($urandom)
                                                : r.start_y + 16'($urandom_range(31, 0)) - 16'd16;
        r.start_heading = (o == 0 || $urandom_range(9, 0) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(o - 1, 0));
        r.goal_heading  = (o == 0 || $urandom_range(9, 0) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(o - 1, 0));
        r.start_steer   = (p == 0 || $urandom_range(9, 0) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(p - 1, 0));
        r.goal_steer    = (p == 0 || $urandom_range(9, 0) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(p - 1, 0));
        return r;
    endfunction

    // Offer one request, hold it until the block takes it, then record its answer.
    task automatic offer_request(input t_pose_req it, input bit typed, input t_answer literal);
        t_answer a;
        @(negedge i_clk);
        while ($urandom_range(99, 0) < req_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.func          = it.func;
        req_ch.start_x       = it.start_x;
        req_ch.start_y       = it.start_y;
        req_ch.start_heading = it.start_heading;
        req_ch.start_steer   = it.start_steer;
        req_ch.goal_x        = it.goal_x;
        req_ch.goal_y        = it.goal_y;
        req_ch.goal_heading  = it.goal_heading;
        req_ch.goal_steer    = it.goal_steer;
        req_ch.cost_in       = it.cost_in;
        req_ch.valid         = 1'b1;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        // Always advance the shadow table; a literal answer only replaces the prediction.
        a = predict_answer(it);
        pending_answers.push_back(typed ? literal : a);
    endtask

    // Drop valid and wait for every outstanding answer before touching registers.
    task automatic settle_idle();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Write both registers, then one unused index that the block must ignore.
    task automatic apply_setting(input logic [7:0] o, input logic [7:0] p);
        logic [shc_pkg::CFG_IDX_W-1:0] junk_idx;
        logic [shc_pkg::CFG_DAT_W-1:0] junk_val;
        junk_idx = shc_pkg::CFG_IDX_W'($urandom_range(CFG_LAST_INDEX, CFG_FIRST_UNUSED));
        junk_val = shc_pkg::CFG_DAT_W'($urandom);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = shc_pkg::CFG_ORIENT_CNT;
        i_cfg_data  = o;
        orient_cnt  = o;
        @(negedge i_clk);
        i_cfg_index = shc_pkg::CFG_STEER_PARTS;
        i_cfg_data  = p;
        steer_parts = p;
        @(negedge i_clk);
        i_cfg_index = junk_idx;
        i_cfg_data  = junk_val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    // Answer checker: compare every accepted answer with the oldest prediction.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            answers_seen = answers_seen + 1;
            if (pending_answers.size() == 0) begin
                $display("%0t: answer with nothing expected: status %0d cost %h key %h",
                         $time, rsp_ch.status, rsp_ch.cost_out, rsp_ch.canon_key);
                fails = fails + 1;
            end else begin
                want = pending_answers.pop_front();
                status_seen[int'(want.status)]++;
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                    fails = fails + 1;
                end
                if (rsp_ch.cost_out !== want.cost) begin
                    $display("%0t: cost_out expected %h actual %h",
                             $time, want.cost, rsp_ch.cost_out);
                    fails = fails + 1;
                end
                if (rsp_ch.canon_key !== want.key) begin
                    $display("%0t: canon_key expected %h actual %h",
                             $time, want.key, rsp_ch.canon_key);
                    fails = fails + 1;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off so the block fills and
    // stalls its request side while the sender keeps offering.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left    = 0;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready = 1'b0;
            end else if (!hold_done && answers_seen >= HOLD_AFTER) begin
                hold_done    = 1'b1;
                hold_left    = LONG_HOLD - 1;
                rsp_ch.ready = 1'b0;
            end else begin
                rsp_ch.ready = ($urandom_range(99, 0) >= rsp_idle_pct);
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #30_000_000;
        $display("FAIL");
        $finish;
    end

    // Stimulus: directed table first, then random phases at several register settings.
    initial begin
        t_dir_row  rows[$];
        t_pose_req pose_pool[$];
        t_pose_req it;
        t_answer   no_literal;
        int        settings_used;
        int        requests_sent;
        logic [7:0] phase_orient [RANDOM_PHASES];
        logic [7:0] phase_steer  [RANDOM_PHASES];

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = shc_pkg::CFG_ORIENT_CNT;
        i_cfg_data    = '0;
        req_ch.valid  = 1'b0;
        req_ch.func   = FN_LOOKUP;
        req_ch.start_x = '0;
        req_ch.start_y = '0;
        req_ch.start_heading = '0;
        req_ch.start_steer   = '0;
        req_ch.goal_x  = '0;
        req_ch.goal_y  = '0;
        req_ch.goal_heading  = '0;
        req_ch.goal_steer    = '0;
        req_ch.cost_in = '0;

        orient_cnt    = shc_pkg::ORIENT_CNT_RST;
        steer_parts   = shc_pkg::STEER_PARTS_RST;
        entries_used  = 0;
        answers_seen  = 0;
        fails         = 0;
        foreach (status_seen[s]) status_seen[s] = 0;
        no_literal    = '0;
        settings_used = 1;
        requests_sent = 0;
        req_idle_pct  = 19;
        rsp_idle_pct  = 59;

        // Heading counts 8 and 255 and steering 1 and 255 are the extremes; 0 is the
        // zero-count case where every remainder passes its dividend through.
        phase_orient = '{8'd8, 8'd255, 8'd0, 8'd16, 8'd32, 8'd255, 8'd8};
        phase_steer  = '{8'd1, 8'd255, 8'd0, 8'd4,  8'd255, 8'd1,  8'd0};

        // Reset defaults (16 headings, 1 partition): literal answers on an empty table.
        rows.push_back(stim_row(16, 1, FN_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, 1, shc_pkg::ST_MISS, 0, 64'h0));
        rows.push_back(stim_row(16, 1, FN_INSERT, 0, 0, 0, 0, 0, 0, 0, 0,
                                32'hFFFF_FFFF, 1, shc_pkg::ST_INSERTED, 0, 64'h0));
        rows.push_back(stim_row(16, 1, FN_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, 1, shc_pkg::ST_HIT, 32'hFFFF_FFFF, 64'h0));
        // Key already present: nothing changes.
        rows.push_back(stim_row(16, 1, FN_INSERT, 0, 0, 0, 0, 0, 0, 0, 0,
                                32'd5, 1, shc_pkg::ST_PRESENT, 0, 64'h0));
        rows.push_back(stim_row(16, 1, FN_LOOKUP, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0,
                                0, 1, shc_pkg::ST_MISS, 0, 64'hFFFF_0000_0000_0000));
        rows.push_back(stim_row(16, 1, FN_LOOKUP, 0, 1, 0, 0, 0, 0, 0, 0,
                                0, 1, shc_pkg::ST_MISS, 0, 64'h0000_FFFF_0000_0000));
        // Coordinate extremes and combinations of the folds.
        rows.push_back(stim_row(16, 1, FN_INSERT, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0,
                                32'h0000_0100, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(16, 1, FN_INSERT, 100, 200, 5, 0, 300, 50, 3, 0,
                                32'h1234_5678, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(16, 1, FN_INSERT, 7, 9, 9, 0, 1, 2, 0, 0,
                                32'h8000_0000, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(16, 1, FN_INSERT, 40, 40, 6, 0, 41, 39, 15, 0,
                                32'h0000_00FF, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(16, 1, FN_LOOKUP, 100, 200, 5, 0, 300, 50, 3, 0,
                                0, 0, shc_pkg::ST_MISS, 0, 0));
        // Indices at or above their counts, then other heading and steering counts.
        rows.push_back(stim_row(16, 1, FN_LOOKUP, 0, 0, 255, 255, 16'hFFFF, 16'hFFFF, 255, 255,
                                0, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(16, 1, FN_INSERT, 0, 0, 13, 0, 8, 8, 7, 0,
                                32'h0F0F_F0F0, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(8, 255, FN_INSERT, 5, 5, 7, 254, 0, 0, 0, 0,
                                32'hDEAD_BEEF, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(8, 255, FN_LOOKUP, 5, 5, 7, 254, 0, 0, 0, 0,
                                0, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(8, 255, FN_LOOKUP, 1, 2, 3, 1, 3, 4, 5, 128,
                                0, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(255, 1, FN_INSERT, 1000, 2000, 200, 0, 3000, 4000, 254, 0,
                                32'h0000_0001, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(255, 1, FN_LOOKUP, 1000, 2000, 200, 0, 3000, 4000, 254, 0,
                                0, 0, shc_pkg::ST_MISS, 0, 0));
        // Zero heading and steering counts, then a zero steering count alone.
        rows.push_back(stim_row(0, 0, FN_INSERT, 10, 10, 1, 3, 20, 5, 9, 200,
                                32'h7FFF_FFFF, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(0, 0, FN_LOOKUP, 10, 10, 0, 0, 20, 5, 0, 0,
                                0, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(0, 0, FN_LOOKUP, 10, 10, 1, 3, 20, 5, 9, 200,
                                0, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(16, 0, FN_LOOKUP, 3, 3, 12, 5, 9, 1, 2, 0,
                                0, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(16, 0, FN_INSERT, 3, 3, 12, 5, 9, 1, 2, 0,
                                32'hAAAA_5555, 0, shc_pkg::ST_MISS, 0, 0));
        rows.push_back(stim_row(16, 0, FN_LOOKUP, 3, 3, 12, 5, 9, 1, 2, 0,
                                0, 0, shc_pkg::ST_MISS, 0, 0));

        // Hold reset, then release it on a falling edge.
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[r]) begin
            if (rows[r].orient != orient_cnt || rows[r].steer != steer_parts) begin
                settle_idle();
                apply_setting(rows[r].orient, rows[r].steer);
                settings_used++;
            end
            offer_request(rows[r].req, rows[r].typed, rows[r].answer);
            requests_sent++;
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle_idle();
            apply_setting(phase_orient[ph], phase_steer[ph]);
            settings_used++;
            // Sender-light/receiver-heavy idling, then the reverse, then none.
            if (ph < 3) begin
                req_idle_pct = 19;
                rsp_idle_pct = 59;
            end else if (ph < 5) begin
                req_idle_pct = 59;
                rsp_idle_pct = 19;
            end else begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                // Revisit known poses often so hits and duplicate inserts stay common.
                if (pose_pool.size() > 0 && $urandom_range(99, 0) < 40) begin
                    it         = pose_pool[$urandom_range(pose_pool.size() - 1, 0)];
                    it.func    = 1'($urandom_range(1, 0));
                    it.cost_in = 32'($urandom);
                end else begin
                    it = random_pose();
                    pose_pool.push_back(it);
                    if (pose_pool.size() > POOL_LIMIT) void'(pose_pool.pop_front());
                end
                offer_request(it, 1'b0, no_literal);
                requests_sent++;
            end
        end

        // Drain: wait for the last answer, then a full scan's worth of quiet cycles.
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests over %0d register settings; table holds %0d of %0d keys.",
                 requests_sent, settings_used, entries_used, TABLE_ENTRIES);
        $display("Answers: %0d hit, %0d miss, %0d inserted, %0d present, %0d dropped full.",
                 status_seen[shc_pkg::ST_HIT], status_seen[shc_pkg::ST_MISS],
                 status_seen[shc_pkg::ST_INSERTED], status_seen[shc_pkg::ST_PRESENT],
                 status_seen[shc_pkg::ST_FULL]);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/shc_pkg.sv
hdl/shc_req_if.sv
hdl/shc_rsp_if.sv
hdl/shc_rem.sv
hdl/shc_front.sv
hdl/shc_fifo.sv
hdl/shc_back.sv
hdl/symmetric_heuristic_cache.sv
tb/sv/tb_top.sv
